// File: hdl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Transport stream packetizer package
// Shared constants, state encoding and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned STREAM_SLOTS = 4;
  localparam int unsigned SLOT_W       = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

  localparam int unsigned TS_SIZE      = 188;
  localparam int unsigned IN_DATA_W    = 128;
  localparam int unsigned OUT_DATA_W   = 32;
  localparam int unsigned OUT_USER_W   = 2;
  localparam int unsigned CFG_W        = 33;

  localparam logic [32:0] DEFAULT_DELAY = 33'd63000;
  localparam logic [7:0]  SYNC_BYTE     = 8'h47;
  localparam logic [7:0]  ADAPT_FLAGS   = 8'h50;
  localparam logic [6:0]  PCR_RESERVED  = 7'h7e;
  localparam logic [7:0]  PES_MARKER    = 8'h80;
  localparam logic [7:0]  STUFF_BYTE    = 8'hff;
  localparam logic [7:0]  LAST_POS      = 8'(TS_SIZE - 1);

  localparam logic ACTION_START = 1'b0;
  localparam logic ACTION_BYTE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_HDR,
    ST_DATA,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load_desc;
    logic take_byte;
    logic setup;
    logic push_hdr;
    logic push_data;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic pos_zero;
    logic hdr_last;
    logic push_ok;
    logic held_valid;
    logic out_free;
  } status_t;

endpackage

// File: hdl/tsp_datapath.sv
// ----------------------------------------------------------------------------
// Transport stream packetizer datapath
// Holds the frame descriptor, continuity counters and header parameters,
// generates header bytes, assembles bytes into words and drives the output.
// ----------------------------------------------------------------------------
module tsp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsp_pkg::cmd_t                 cmd_i,
  output tsp_pkg::status_t              sts_o,
  input  logic [tsp_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [tsp_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [31:0]                   m_word_o,
  output logic                          m_pend_o,
  output logic                          m_fend_o,
  output logic                          m_last_o
);
  import tsp_pkg::*;

  logic [32:0] delay_q;
  logic [3:0]  cc_q [STREAM_SLOTS];
  logic [SLOT_W-1:0] slot_q;
  logic [12:0] pid_q;
  logic [7:0]  sid_q;
  logic [32:0] pts_q, dts_q;
  logic        key_q;
  logic [23:0] len_q, rem_q;
  logic [7:0]  pos_q;
  logic        first_q;
  logic [23:0] asm_q;
  logic [1:0]  fill_q;
  logic [7:0]  byte_q;

  logic        adapt_q, wd_q;
  logic [7:0]  stuff_q, alen_q, htot_q, k_q;
  logic [3:0]  cc_cur_q;
  logic [32:0] pcr_q, ptsd_q, dtsd_q;
  logic [15:0] pes_q;

  logic        held_v_q, held_pend_q, held_fend_q;
  logic [31:0] held_q;
  logic        out_v_q, out_pend_q, out_fend_q, out_last_q;
  logic [31:0] out_q;

  logic        s_wd, s_adapt;
  logic [7:0]  s_hlen, s_body, s_stuff;
  logic [24:0] s_pes;
  logic [3:0]  s_cc;
  logic [SLOT_W-1:0] in_slot;

  logic [7:0]  hbyte, pbyte, j, p;
  logic [3:0]  fb;
  logic [32:0] sv;
  logic [2:0]  si;
  logic        push, word_done, pend;
  logic [31:0] word;

  assign in_slot = SLOT_W'(32'(in_data_i[1:0]) % STREAM_SLOTS);

  // Header parameters for the packet about to start.
  always_comb begin
    s_wd    = (dts_q != pts_q);
    s_adapt = first_q & key_q;
    s_hlen  = 8'd4 + (s_adapt ? 8'd8 : 8'd0) + (first_q ? (s_wd ? 8'd19 : 8'd14) : 8'd0);
    s_body  = 8'(TS_SIZE) - s_hlen;
    s_stuff = (rem_q < {16'd0, s_body}) ? (s_body - rem_q[7:0]) : 8'd0;
    s_pes   = {1'b0, len_q} + (s_wd ? 25'd13 : 25'd8);
    s_cc    = cc_q[slot_q] + 4'd1;
  end

  // Header byte at position k_q.
  always_comb begin
    j     = k_q - 8'd4;
    p     = k_q - 8'd4 - alen_q;
    fb    = 4'd1;
    sv    = dtsd_q;
    si    = 3'd0;
    pbyte = 8'h00;
    if (p < 8'd14) begin
      fb = wd_q ? 4'd3 : 4'd2;
      sv = ptsd_q;
      si = 3'(p - 8'd9);
    end else begin
      si = 3'(p - 8'd14);
    end
    unique case (p)
      8'd0, 8'd1: pbyte = 8'h00;
      8'd2:       pbyte = 8'h01;
      8'd3:       pbyte = sid_q;
      8'd4:       pbyte = pes_q[15:8];
      8'd5:       pbyte = pes_q[7:0];
      8'd6:       pbyte = PES_MARKER;
      8'd7:       pbyte = {1'b1, wd_q, 6'd0};
      8'd8:       pbyte = wd_q ? 8'd10 : 8'd5;
      default: begin
        unique case (si)
          3'd0:    pbyte = {fb, sv[32:30], 1'b1};
          3'd1:    pbyte = sv[29:22];
          3'd2:    pbyte = {sv[21:15], 1'b1};
          3'd3:    pbyte = sv[14:7];
          default: pbyte = {sv[6:0], 1'b1};
        endcase
      end
    endcase
    if (k_q == 8'd0) begin
      hbyte = SYNC_BYTE;
    end else if (k_q == 8'd1) begin
      hbyte = {1'b0, first_q, 1'b0, pid_q[12:8]};
    end else if (k_q == 8'd2) begin
      hbyte = pid_q[7:0];
    end else if (k_q == 8'd3) begin
      hbyte = {2'b00, adapt_q | (stuff_q != 8'd0), 1'b1, cc_cur_q};
    end else if (j < alen_q) begin
      if (adapt_q) begin
        unique case (j)
          8'd0:    hbyte = 8'd7 + stuff_q;
          8'd1:    hbyte = ADAPT_FLAGS;
          8'd2:    hbyte = pcr_q[32:25];
          8'd3:    hbyte = pcr_q[24:17];
          8'd4:    hbyte = pcr_q[16:9];
          8'd5:    hbyte = pcr_q[8:1];
          8'd6:    hbyte = {pcr_q[0], PCR_RESERVED};
          8'd7:    hbyte = 8'h00;
          default: hbyte = STUFF_BYTE;
        endcase
      end else begin
        unique case (j)
          8'd0:    hbyte = stuff_q - 8'd1;
          8'd1:    hbyte = 8'h00;
          default: hbyte = STUFF_BYTE;
        endcase
      end
    end else begin
      hbyte = pbyte;
    end
  end

  assign push      = cmd_i.push_hdr | cmd_i.push_data;
  assign word_done = push && (fill_q == 2'd3);
  assign pend      = (pos_q == LAST_POS);
  assign word      = {asm_q, cmd_i.push_hdr ? hbyte : byte_q};

  assign sts_o.rem_zero   = (rem_q == 24'd0);
  assign sts_o.pos_zero   = (pos_q == 8'd0);
  assign sts_o.hdr_last   = (k_q == htot_q - 8'd1);
  assign sts_o.out_free   = !out_v_q || m_ready_i;
  assign sts_o.push_ok    = !((fill_q == 2'd3) && held_v_q && !sts_o.out_free);
  assign sts_o.held_valid = held_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DEFAULT_DELAY;
      for (int i = 0; i < STREAM_SLOTS; i++) cc_q[i] <= 4'd0;
      slot_q   <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      first_q  <= 1'b0;
      asm_q    <= '0;
      fill_q   <= '0;
      k_q      <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) delay_q <= cfg_data_i;
      if ((word_done && held_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.load_desc) begin
        slot_q  <= in_slot;
        rem_q   <= in_data_i[113:90];
        pos_q   <= '0;
        first_q <= (in_data_i[113:90] != 24'd0);
        asm_q   <= '0;
        fill_q  <= '0;
      end
      if (cmd_i.setup) begin
        cc_q[slot_q] <= s_cc;
        k_q          <= '0;
      end
      if (cmd_i.push_hdr) begin
        if (sts_o.hdr_last) begin
          k_q     <= '0;
          first_q <= 1'b0;
        end else begin
          k_q <= k_q + 8'd1;
        end
      end
      if (cmd_i.push_data) rem_q <= rem_q - 24'd1;
      if (push) begin
        pos_q <= pend ? 8'd0 : pos_q + 8'd1;
        if (word_done) begin
          asm_q    <= '0;
          fill_q   <= '0;
          held_v_q <= 1'b1;
        end else begin
          asm_q  <= {asm_q[15:0], cmd_i.push_hdr ? hbyte : byte_q};
          fill_q <= fill_q + 2'd1;
        end
      end
      if (cmd_i.flush) begin
        held_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_desc) begin
      pid_q <= in_data_i[14:2];
      sid_q <= in_data_i[22:15];
      pts_q <= in_data_i[55:23];
      dts_q <= in_data_i[88:56];
      key_q <= in_data_i[89];
      len_q <= in_data_i[113:90];
    end
    if (cmd_i.take_byte) byte_q <= in_data_i[121:114];
    if (cmd_i.setup) begin
      wd_q     <= s_wd;
      adapt_q  <= s_adapt;
      stuff_q  <= s_stuff;
      alen_q   <= s_adapt ? s_stuff + 8'd8 : s_stuff;
      htot_q   <= s_hlen + s_stuff;
      cc_cur_q <= s_cc;
      pcr_q    <= dts_q - delay_q;
      ptsd_q   <= pts_q + delay_q;
      dtsd_q   <= dts_q + delay_q;
      pes_q    <= (s_pes > 25'h00ffff) ? 16'd0 : s_pes[15:0];
    end
    if (word_done) begin
      held_q      <= word;
      held_pend_q <= pend;
      held_fend_q <= pend && cmd_i.push_data && (rem_q == 24'd1);
      if (held_v_q) begin
        out_q      <= held_q;
        out_pend_q <= held_pend_q;
        out_fend_q <= held_fend_q;
        out_last_q <= 1'b0;
      end
    end
    if (cmd_i.flush) begin
      out_q      <= held_q;
      out_pend_q <= held_pend_q;
      out_fend_q <= held_fend_q;
      out_last_q <= 1'b1;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_word_o  = out_q;
  assign m_pend_o  = out_pend_q;
  assign m_fend_o  = out_fend_q;
  assign m_last_o  = out_last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 8'(TS_SIZE)) else $error("packet position out of range");
  a_pos_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[1:0] == fill_q) else $error("assembler out of step with packet");
  a_word_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_done && held_v_q) |-> sts_o.out_free) else $error("output overrun");

endmodule

// File: hdl/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// Transport stream packetizer controller
// Sequences descriptor loads, header generation, payload bytes and the
// final word flush of each input beat.
// ----------------------------------------------------------------------------
module tsp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_action_i,
  output logic             s_ready_o,
  output tsp_pkg::cmd_t    cmd_o,
  input  tsp_pkg::status_t sts_i
);
  import tsp_pkg::*;

  state_e state_q, state_d;
  logic   acc;

  assign acc = s_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && s_action_i == ACTION_BYTE && !sts_i.rem_zero) begin
          state_d = sts_i.pos_zero ? ST_SETUP : ST_DATA;
        end
      end
      ST_SETUP: state_d = ST_HDR;
      ST_HDR: begin
        if (sts_i.push_ok && sts_i.hdr_last) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (sts_i.push_ok) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!sts_i.held_valid || sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_desc = acc && (s_action_i == ACTION_START);
        cmd_o.take_byte = acc && (s_action_i == ACTION_BYTE);
      end
      ST_SETUP: cmd_o.setup     = 1'b1;
      ST_HDR:   cmd_o.push_hdr  = sts_i.push_ok;
      ST_DATA:  cmd_o.push_data = sts_i.push_ok;
      ST_FLUSH: cmd_o.flush     = sts_i.held_valid && sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.held_valid) else $error("word left behind");
  a_setup_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |=> (state_q == ST_HDR)) else $error("setup not followed by header");
  a_one_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.push_hdr && cmd_o.push_data)) else $error("two byte sources at once");

endmodule

// File: hdl/ts_pes_packetizer_top.sv
// ----------------------------------------------------------------------------
// Transport stream PES packetizer
// Cuts elementary-stream frames into 188-byte transport packets as 32-bit words.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis: tuser 0 is a frame start with its descriptor,
// tuser 1 carries one payload byte. Output beats leave on m_axis as 32-bit
// big-endian words, with tlast on the last word caused by an input beat and
// tuser marking packet end and frame end.
// The pcr_delay register is written on the cfg channel while the block is idle;
// the user must keep to this, as the block does not enforce it. A payload byte
// inside a packet passes through accept, byte push and flush. The first byte of
// a packet adds a setup step and 4 to 187 header and stuffing bytes, produced
// one byte per cycle by the byte assembler while the output does not stall. Each
// word passes a holding register and then the output register to reach m_axis.
// After reset the continuity counters are zero, no frame is open and
// pcr_delay is 63000. When the receiver stalls, one word waits in the output
// register and one in a holding register; further bytes then wait until the
// output register drains, and no input beat is taken.
// ----------------------------------------------------------------------------
module ts_pes_packetizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot[1:0] pid[14:2] stream_id[22:15] pts[55:23] dts[88:56] key_frame[89]
  // frame_length[113:90] data_byte[121:114], zero above
  input  logic [tsp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // action[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_word[31:0]
  output logic [tsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // packet_end[0] frame_end[1]
  output logic [tsp_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsp_pkg::CFG_W-1:0]     cfg_data_i
);
  import tsp_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  tsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tsp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_word_o    (m_axis_tdata),
    .m_pend_o    (m_axis_tuser[0]),
    .m_fend_o    (m_axis_tuser[1]),
    .m_last_o    (m_axis_tlast)
  );

endmodule
